/* rtl/tct_pkg.sv */
`default_nettype none

package tct_pkg;

  // One configured color, five bits per channel, red in the top bits.
  typedef struct packed {
    logic [4:0] red;
    logic [4:0] green;
    logic [4:0] blue;
  } color_t;

  // The three configured colors as a group.
  typedef struct packed {
    color_t base;
    color_t first_tint;
    color_t second_tint;
  } palette_t;

  // One source or result pixel.
  typedef struct packed {
    logic       last;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_BASE_COLOR   = 2'd0;
  localparam logic [1:0] REG_FIRST_TINT   = 2'd1;
  localparam logic [1:0] REG_SECOND_TINT  = 2'd2;

  localparam int unsigned COLOR_W      = 15;
  localparam int unsigned SUM_W        = 15;
  localparam logic [12:0] CLAMP_LIMIT  = 13'd8191;
  localparam logic [7:0]  FULL_WEIGHT  = 8'd255;
  localparam logic [4:0]  HIGHLIGHT_GAIN = 5'd31;

endpackage

`default_nettype wire

/* rtl/two_color_highlight_tint.sv */
`default_nettype none

// Two-color tint with white highlight. Each incoming pixel is read as three
// weights: red weights the first tint color, green the second tint color and
// blue a white highlight; blue is first subtracted (modulo 256) from red and
// green. Every output channel is the clamped weighted sum of the configured
// 5-bit colors scaled down to a byte, and tlast passes through as the
// end-of-image mark. The block takes one pixel transfer per clock and keeps
// doing so while the output is drained every cycle. A pixel transferred in
// is held in the input register, then in the result register, which offers it
// on the output. A stalled output stops the input only once both registers
// are full. The user must write colors through the cfg port only while no
// pixel is in flight; the block itself does not enforce this. Reset clears
// all three colors to black.
module two_color_highlight_tint (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data,
  // Input pixel stream.
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [23:0] s_tdata,  // in_red [7:0], in_green [15:8], in_blue [23:16]
  input  wire logic        s_tlast,  // last_pixel
  // Output pixel stream.
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [23:0] m_tdata,  // out_red [7:0], out_green [15:8], out_blue [23:16]
  output      logic        m_tlast   // end_of_image
);

  tct_pkg::palette_t palette;

  tct_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .palette   (palette)
  );

  // Stage one holds the accepted pixel; stage two holds the finished result.
  logic              in_valid;
  tct_pkg::pixel_t   in_pix;
  logic              out_valid;
  tct_pkg::pixel_t   out_pix;
  tct_pkg::pixel_t   out_pix_next;
  logic              out_ready;
  logic              in_ready;

  // Each stage may load when it is empty or when its content moves on.
  assign out_ready = !out_valid || m_tready;
  assign in_ready  = !in_valid || out_ready;
  assign s_tready  = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && s_tvalid) begin
      in_pix <= {s_tlast, s_tdata[23:16], s_tdata[15:8], s_tdata[7:0]};
    end
  end

  // Blue is taken out of the two tint weights; the wrap is intended.
  logic [7:0] red_weight;
  logic [7:0] green_weight;

  assign red_weight   = in_pix.red   - in_pix.blue;
  assign green_weight = in_pix.green - in_pix.blue;

  tct_channel u_red (
    .base_c       (palette.base.red),
    .first_c      (palette.first_tint.red),
    .second_c     (palette.second_tint.red),
    .red_weight   (red_weight),
    .green_weight (green_weight),
    .highlight    (in_pix.blue),
    .value        (out_pix_next.red)
  );

  tct_channel u_green (
    .base_c       (palette.base.green),
    .first_c      (palette.first_tint.green),
    .second_c     (palette.second_tint.green),
    .red_weight   (red_weight),
    .green_weight (green_weight),
    .highlight    (in_pix.blue),
    .value        (out_pix_next.green)
  );

  tct_channel u_blue (
    .base_c       (palette.base.blue),
    .first_c      (palette.first_tint.blue),
    .second_c     (palette.second_tint.blue),
    .red_weight   (red_weight),
    .green_weight (green_weight),
    .highlight    (in_pix.blue),
    .value        (out_pix_next.blue)
  );

  assign out_pix_next.last = in_pix.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && in_valid) begin
      out_pix <= out_pix_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_pix.blue, out_pix.green, out_pix.red};
  assign m_tlast  = out_pix.last;

endmodule

`default_nettype wire

/* rtl/tct_cfg.sv */
`default_nettype none

module tct_cfg (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [tct_pkg::COLOR_W-1:0] cfg_data,
  output tct_pkg::palette_t              palette
);

  tct_pkg::palette_t palette_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      palette_reg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tct_pkg::REG_BASE_COLOR:  palette_reg.base        <= cfg_data;
        tct_pkg::REG_FIRST_TINT:  palette_reg.first_tint  <= cfg_data;
        tct_pkg::REG_SECOND_TINT: palette_reg.second_tint <= cfg_data;
        default: ;  // Writes beyond the register list are dropped.
      endcase
    end
  end

  assign palette = palette_reg;

endmodule

`default_nettype wire

/* rtl/tct_channel.sv */
`default_nettype none

module tct_channel (
  input  wire logic [4:0] base_c,
  input  wire logic [4:0] first_c,
  input  wire logic [4:0] second_c,
  input  wire logic [7:0] red_weight,
  input  wire logic [7:0] green_weight,
  input  wire logic [7:0] highlight,
  output      logic [7:0] value
);

  logic [7:0]                  base_weight;
  logic [12:0]                 prod_high;
  logic [12:0]                 prod_base;
  logic [12:0]                 prod_first;
  logic [12:0]                 prod_second;
  logic [tct_pkg::SUM_W-1:0]   sum;
  logic [12:0]                 sat;

  // The base color takes whatever weight the first tint leaves.
  assign base_weight = tct_pkg::FULL_WEIGHT - red_weight;

  assign prod_high   = 13'(tct_pkg::HIGHLIGHT_GAIN) * 13'(highlight);
  assign prod_base   = 13'(base_c)   * 13'(base_weight);
  assign prod_first  = 13'(first_c)  * 13'(red_weight);
  assign prod_second = 13'(second_c) * 13'(green_weight);

  assign sum = tct_pkg::SUM_W'(prod_high) + tct_pkg::SUM_W'(prod_base)
             + tct_pkg::SUM_W'(prod_first) + tct_pkg::SUM_W'(prod_second);

  assign sat   = (sum > tct_pkg::SUM_W'(tct_pkg::CLAMP_LIMIT)) ? tct_pkg::CLAMP_LIMIT
                                                               : sum[12:0];
  assign value = sat[12:5];

endmodule

`default_nettype wire
